// ===== src/char_lcd_shadow_write_filter_assert.svh =====
// Assertion macros shared by the shadow write filter modules.
`ifndef CHAR_LCD_SHADOW_WRITE_FILTER_ASSERT_SVH
`define CHAR_LCD_SHADOW_WRITE_FILTER_ASSERT_SVH

// Same-cycle implication, clocked on clk and switched off during rst.
`define CLSWF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and switched off during rst.
`define CLSWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/clswf_pkg.sv =====
// Shared types, codes and constants of the character LCD shadow write filter.
`timescale 1ns / 1ps

package clswf_pkg;

  localparam int CHAR_DEPTH_DEF  = 128;
  localparam int GLYPH_DEPTH_DEF = 64;
  localparam int VA_W            = 8;
  localparam int DELAY_W         = 16;
  localparam int CFG_INDEX_W     = 3;
  // Result queue depth; a power of two so that the pointers wrap naturally.
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] GLYPH_BLANK  = 8'hFF;
  localparam logic [7:0] MODE_UNKNOWN = 8'hFF;

  localparam logic [7:0] OPC_CLEAR    = 8'h01;
  localparam logic [7:0] OPC_HOME     = 8'h02;
  localparam logic [7:0] OPC_ENTRY    = 8'h04;
  localparam logic [7:0] OPC_DISPLAY  = 8'h08;
  localparam logic [7:0] OPC_SHIFT    = 8'h10;
  localparam logic [7:0] OPC_FUNCTION = 8'h20;
  localparam logic [7:0] OPC_GLYPH    = 8'h40;
  localparam logic [7:0] OPC_DISPADDR = 8'h80;

  localparam logic [DELAY_W-1:0] CLEAR_DELAY_RST   = 16'd1640;
  localparam logic [DELAY_W-1:0] HOME_DELAY_RST    = 16'd1640;
  localparam logic [DELAY_W-1:0] COMMAND_DELAY_RST = 16'd40;
  localparam logic [DELAY_W-1:0] FLUSH_DELAY_RST   = 16'd15000;

  typedef enum logic [3:0] {
    OP_CLEAR     = 4'd0,
    OP_HOME      = 4'd1,
    OP_ENTRY     = 4'd2,
    OP_DISPLAY   = 4'd3,
    OP_SHIFT     = 4'd4,
    OP_FUNCTION  = 4'd5,
    OP_GLYPH     = 4'd6,
    OP_DISPADDR  = 4'd7,
    OP_WRITE     = 4'd8,
    OP_FORGET    = 4'd9
  } op_code_t;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_PAUSE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_ENTRY    = 2'd0,
    SLOT_DISPLAY  = 2'd1,
    SLOT_SHIFT    = 2'd2,
    SLOT_FUNCTION = 2'd3
  } slot_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLEAR_DELAY   = 3'd0,
    CFG_HOME_DELAY    = 3'd1,
    CFG_COMMAND_DELAY = 3'd2,
    CFG_FLUSH_DELAY   = 3'd3
  } cfg_index_t;

  typedef struct packed {
    logic [3:0] operation;
    logic [2:0] option_bits;
    logic [6:0] ram_address;
    logic [7:0] data_byte;
  } op_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         bus_byte;
    logic [DELAY_W-1:0] delay_us;
    logic               to_all_controllers;
    logic               last;
  } bus_item_t;

  // Up to two results handed to the result queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    bus_item_t  first;
    bus_item_t  second;
  } push_t;

endpackage

// ===== src/clswf_out_fifo.sv =====
// Result queue: takes up to two results a cycle and hands out one a cycle unless bus_stall holds it.
`timescale 1ns / 1ps
`include "char_lcd_shadow_write_filter_assert.svh"

module clswf_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  clswf_pkg::push_t     push,
  output logic                 room,
  output logic                 bus_valid,
  input  logic                 bus_stall,
  output clswf_pkg::bus_item_t bus_item
);

  localparam int DEPTH = clswf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  clswf_pkg::bus_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             pop;

  assign pop       = bus_valid && !bus_stall;
  assign bus_valid = (cnt != '0);
  assign bus_item  = entries[rd_ptr];
  // Room for a full pair of results, whatever leaves this cycle.
  assign room      = (cnt <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      cnt    <= cnt + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  `CLSWF_ASSERT_NOW(a_push_has_room, push.count != 2'd0, room, "results pushed without room")
  `CLSWF_ASSERT_NOW(a_count_bound, 1'b1, cnt <= CNT_W'(DEPTH), "result queue overflow")
  `CLSWF_ASSERT_NEXT(a_pop_drains, pop && push.count == 2'd0, cnt == $past(cnt) - CNT_W'(1), "queue count did not drop on a pop")

endmodule

// ===== src/char_lcd_shadow_write_filter.sv =====
// Top level of the character LCD shadow write filter.
`timescale 1ns / 1ps
`include "char_lcd_shadow_write_filter_assert.svh"

// An accepted item waits in the input register until the result queue has room for two results,
// is then decided, and its results go out on bus_item through the result queue.
// Throughput: one item per cycle while the queue has room for a pair; an item with two results
// leaves one result at a time through the single result port, and the queue holds up to four.
// Reset (rst, synchronous) restores the delay registers and mode shadow directly and the shadow
// memories through valid bits, so there is no clearing pass and items are taken once rst drops.

module char_lcd_shadow_write_filter #(
  parameter int CHAR_DEPTH  = clswf_pkg::CHAR_DEPTH_DEF,
  parameter int GLYPH_DEPTH = clswf_pkg::GLYPH_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 op_valid,
  output logic                                 op_stall,
  input  clswf_pkg::op_item_t                  op_item,
  output logic                                 bus_valid,
  input  logic                                 bus_stall,
  output clswf_pkg::bus_item_t                 bus_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [clswf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clswf_pkg::DELAY_W-1:0]        cfg_data
);

  localparam int VA_W     = clswf_pkg::VA_W;
  localparam int DW       = clswf_pkg::DELAY_W;
  localparam int CHAR_AW  = $clog2(CHAR_DEPTH);
  localparam int GLYPH_AW = $clog2(GLYPH_DEPTH);

  // Builds one result item.
  function automatic clswf_pkg::bus_item_t make_item(input logic [1:0] kind,
                                                     input logic [7:0] byte_val,
                                                     input logic [DW-1:0] dly,
                                                     input logic all_ctl,
                                                     input logic fin);
    clswf_pkg::bus_item_t item;
    item.kind               = kind;
    item.bus_byte           = byte_val;
    item.delay_us           = dly;
    item.to_all_controllers = all_ctl;
    item.last               = fin;
    return item;
  endfunction

  // Delay registers, written from the configuration channel.
  logic [DW-1:0] clear_delay;
  logic [DW-1:0] home_delay;
  logic [DW-1:0] command_delay;
  logic [DW-1:0] flush_delay;

  // Input register holding the item being decided.
  clswf_pkg::op_item_t in_q;
  logic                in_q_valid;
  logic                accept;
  logic                fire;
  logic                room;

  // Controller tracking state.
  logic [VA_W-1:0] va;
  logic [VA_W-1:0] aa;
  logic            glyph_mode;
  logic [3:0][7:0] mode_shadow;
  logic [VA_W-1:0] va_next;
  logic [VA_W-1:0] aa_next;
  logic            glyph_mode_next;

  // Shadow memories. An entry whose valid bit is clear reads as its reset value.
  logic [7:0]             char_mem  [CHAR_DEPTH];
  logic [7:0]             glyph_mem [GLYPH_DEPTH];
  logic [CHAR_DEPTH-1:0]  char_valid;
  logic [GLYPH_DEPTH-1:0] glyph_valid;
  logic [7:0]             char_rd;
  logic [7:0]             glyph_rd;
  logic [VA_W-1:0]        rd_va;
  logic [CHAR_AW-1:0]     char_idx;
  logic [GLYPH_AW-1:0]    glyph_idx;
  logic                   char_in_range;
  logic                   glyph_in_range;
  logic                   data_in_range;
  logic [7:0]             char_cur;
  logic [7:0]             glyph_cur;

  // Decisions for the item in the input register.
  logic                 char_we;
  logic                 glyph_we;
  logic                 char_clear;
  logic                 forget;
  logic                 mode_sel;
  logic [1:0]           mode_slot;
  logic [7:0]           mode_opc;
  logic                 mode_we;
  clswf_pkg::push_t     push;
  clswf_pkg::push_t     push_q;

  assign cfg_ready = 1'b1;

  // The item in the input register is decided once the result queue can take two results.
  assign fire     = in_q_valid && room;
  assign op_stall = in_q_valid && !fire;
  assign accept   = op_valid && !op_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_delay   <= clswf_pkg::CLEAR_DELAY_RST;
      home_delay    <= clswf_pkg::HOME_DELAY_RST;
      command_delay <= clswf_pkg::COMMAND_DELAY_RST;
      flush_delay   <= clswf_pkg::FLUSH_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clswf_pkg::CFG_CLEAR_DELAY:   clear_delay   <= cfg_data;
        clswf_pkg::CFG_HOME_DELAY:    home_delay    <= cfg_data;
        clswf_pkg::CFG_COMMAND_DELAY: command_delay <= cfg_data;
        clswf_pkg::CFG_FLUSH_DELAY:   flush_delay   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= op_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  // Indices into the shadows. The read for a new item is issued as it is accepted, at the
  // address the item now being decided leaves behind; a write of that item always lands one
  // entry below, so no read meets a write to the same entry.
  assign char_idx       = va[CHAR_AW-1:0];
  assign glyph_idx      = va[GLYPH_AW-1:0];
  assign rd_va          = fire ? va_next : va;
  assign char_in_range  = (va < VA_W'(CHAR_DEPTH));
  assign glyph_in_range = (va < VA_W'(GLYPH_DEPTH));
  assign data_in_range  = glyph_mode ? glyph_in_range : char_in_range;
  assign char_cur       = (char_in_range && char_valid[char_idx]) ? char_rd
                                                                  : clswf_pkg::CHAR_SPACE;
  assign glyph_cur      = (glyph_in_range && glyph_valid[glyph_idx]) ? glyph_rd
                                                                     : clswf_pkg::GLYPH_BLANK;

  always_ff @(posedge clk) begin
    if (fire && char_we) begin
      char_mem[char_idx] <= in_q.data_byte;
    end
    if (accept) begin
      char_rd <= char_mem[rd_va[CHAR_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && glyph_we) begin
      glyph_mem[glyph_idx] <= in_q.data_byte;
    end
    if (accept) begin
      glyph_rd <= glyph_mem[rd_va[GLYPH_AW-1:0]];
    end
  end

  // Decode of one operation into state updates and up to two results.
  always_comb begin
    push            = '0;
    va_next         = va;
    aa_next         = aa;
    glyph_mode_next = glyph_mode;
    char_we         = 1'b0;
    glyph_we        = 1'b0;
    char_clear      = 1'b0;
    forget          = 1'b0;
    mode_sel        = 1'b0;
    mode_slot       = clswf_pkg::SLOT_ENTRY;
    mode_opc        = '0;
    mode_we         = 1'b0;

    case (in_q.operation)
      clswf_pkg::OP_CLEAR: begin
        char_clear      = 1'b1;
        glyph_mode_next = 1'b0;
        va_next         = '0;
        aa_next         = '0;
        push.count      = 2'd1;
        push.first      = make_item(clswf_pkg::KIND_CMD, clswf_pkg::OPC_CLEAR,
                                    clear_delay, 1'b0, 1'b1);
      end
      clswf_pkg::OP_HOME: begin
        glyph_mode_next = 1'b0;
        va_next         = '0;
        aa_next         = '0;
        push.count      = 2'd1;
        push.first      = make_item(clswf_pkg::KIND_CMD, clswf_pkg::OPC_HOME,
                                    home_delay, 1'b0, 1'b1);
      end
      clswf_pkg::OP_ENTRY: begin
        mode_sel  = 1'b1;
        mode_slot = clswf_pkg::SLOT_ENTRY;
        mode_opc  = clswf_pkg::OPC_ENTRY | {6'd0, in_q.option_bits[1:0]};
      end
      clswf_pkg::OP_DISPLAY: begin
        mode_sel  = 1'b1;
        mode_slot = clswf_pkg::SLOT_DISPLAY;
        mode_opc  = clswf_pkg::OPC_DISPLAY | {5'd0, in_q.option_bits};
      end
      clswf_pkg::OP_SHIFT: begin
        mode_sel  = 1'b1;
        mode_slot = clswf_pkg::SLOT_SHIFT;
        mode_opc  = clswf_pkg::OPC_SHIFT | {4'd0, in_q.option_bits[1:0], 2'd0};
      end
      clswf_pkg::OP_FUNCTION: begin
        mode_sel  = 1'b1;
        mode_slot = clswf_pkg::SLOT_FUNCTION;
        mode_opc  = clswf_pkg::OPC_FUNCTION | {3'd0, in_q.option_bits, 2'd0};
      end
      clswf_pkg::OP_GLYPH: begin
        glyph_mode_next = 1'b1;
        va_next         = {2'd0, in_q.ram_address[5:0]};
        aa_next         = {2'd0, in_q.ram_address[5:0]};
        push.count      = 2'd1;
        push.first      = make_item(clswf_pkg::KIND_CMD,
                                    clswf_pkg::OPC_GLYPH | {2'd0, in_q.ram_address[5:0]},
                                    command_delay, 1'b1, 1'b1);
      end
      clswf_pkg::OP_DISPADDR: begin
        glyph_mode_next = 1'b0;
        va_next         = {1'b0, in_q.ram_address};
        aa_next         = {1'b0, in_q.ram_address};
        push.count      = 2'd1;
        push.first      = make_item(clswf_pkg::KIND_CMD,
                                    clswf_pkg::OPC_DISPADDR | {1'b0, in_q.ram_address},
                                    command_delay, 1'b0, 1'b1);
      end
      clswf_pkg::OP_WRITE: begin
        // Past the end of the active RAM nothing is sent and the address holds;
        // the glyph address therefore stops at the glyph depth.
        if (glyph_mode && glyph_in_range) begin
          va_next = va + VA_W'(1);
          if (glyph_cur != in_q.data_byte) begin
            glyph_we = 1'b1;
            aa_next  = va + VA_W'(1);
            if (va != aa) begin
              push.count  = 2'd2;
              push.first  = make_item(clswf_pkg::KIND_CMD,
                                      clswf_pkg::OPC_GLYPH | {2'd0, va[5:0]},
                                      command_delay, 1'b1, 1'b0);
              push.second = make_item(clswf_pkg::KIND_DATA, in_q.data_byte,
                                      command_delay, 1'b1, 1'b1);
            end else begin
              push.count = 2'd1;
              push.first = make_item(clswf_pkg::KIND_DATA, in_q.data_byte,
                                     command_delay, 1'b1, 1'b1);
            end
          end
        end else if (!glyph_mode && char_in_range) begin
          va_next = va + VA_W'(1);
          if (char_cur != in_q.data_byte) begin
            char_we = 1'b1;
            aa_next = va + VA_W'(1);
            if (va != aa) begin
              push.count  = 2'd2;
              push.first  = make_item(clswf_pkg::KIND_CMD,
                                      clswf_pkg::OPC_DISPADDR | {1'b0, va[6:0]},
                                      command_delay, 1'b0, 1'b0);
              push.second = make_item(clswf_pkg::KIND_DATA, in_q.data_byte,
                                      command_delay, 1'b0, 1'b1);
            end else begin
              push.count = 2'd1;
              push.first = make_item(clswf_pkg::KIND_DATA, in_q.data_byte,
                                     command_delay, 1'b0, 1'b1);
            end
          end
        end
      end
      clswf_pkg::OP_FORGET: begin
        forget     = 1'b1;
        push.count = 2'd1;
        push.first = make_item(clswf_pkg::KIND_PAUSE, 8'd0, flush_delay, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase

    // A mode command goes out only when it differs from the last one sent in its slot.
    if (mode_sel && (mode_shadow[mode_slot] != mode_opc)) begin
      mode_we    = 1'b1;
      push.count = 2'd1;
      push.first = make_item(clswf_pkg::KIND_CMD, mode_opc, command_delay, 1'b0, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va          <= '0;
      aa          <= '0;
      glyph_mode  <= 1'b0;
      mode_shadow <= {4{clswf_pkg::MODE_UNKNOWN}};
      char_valid  <= '0;
      glyph_valid <= '0;
    end else if (fire) begin
      va         <= va_next;
      aa         <= aa_next;
      glyph_mode <= glyph_mode_next;
      if (forget) begin
        mode_shadow <= {4{clswf_pkg::MODE_UNKNOWN}};
      end else if (mode_we) begin
        mode_shadow[mode_slot] <= mode_opc;
      end
      if (char_clear) begin
        char_valid <= '0;
      end else if (char_we) begin
        char_valid[char_idx] <= 1'b1;
      end
      if (glyph_we) begin
        glyph_valid[glyph_idx] <= 1'b1;
      end
    end
  end

  // Results reach the queue only when the item is really decided.
  always_comb begin
    push_q = push;
    if (!fire) begin
      push_q.count = 2'd0;
    end
  end

  clswf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_q),
    .room      (room),
    .bus_valid (bus_valid),
    .bus_stall (bus_stall),
    .bus_item  (bus_item)
  );

  `CLSWF_ASSERT_NEXT(a_clear_resets, fire && in_q.operation == clswf_pkg::OP_CLEAR, char_valid == '0 && va == '0 && aa == '0, "clear did not reset the display state")
  `CLSWF_ASSERT_NEXT(a_write_steps, fire && in_q.operation == clswf_pkg::OP_WRITE && data_in_range, va == $past(va) + VA_W'(1), "write address did not advance")
  `CLSWF_ASSERT_NEXT(a_mode_quiet, fire && mode_sel && push.count == 2'd0, $stable(mode_shadow), "suppressed mode command changed the shadow")

endmodule
